// ----- design/sha256_pkg.sv -----
// Package with SHA-256 payload types, constant tables and round functions.
package sha256_pkg;

    typedef struct packed {
        logic       op;
        logic [7:0] data_byte;
    } sha_in_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic        last_word;
    } sha_out_t;

    localparam logic OP_BYTE   = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    function automatic logic [31:0] round_k(input logic [5:0] t);
        logic [31:0] k;
        begin
            unique case (t)
                6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491;
                6'd2:  k = 32'hb5c0fbcf; 6'd3:  k = 32'he9b5dba5;
                6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
                6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5;
                6'd8:  k = 32'hd807aa98; 6'd9:  k = 32'h12835b01;
                6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
                6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
                6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
                6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
                6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
                6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
                6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
                6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
                6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
                6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
                6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
                6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
                6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
                6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
                6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
                6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
                6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
                6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
                6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
                6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
                6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
                6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
                6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
                6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
                6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
                6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
                6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
                default: k = 32'h0;
            endcase
            return k;
        end
    endfunction

    function automatic logic [31:0] initial_h(input logic [2:0] i);
        logic [31:0] h;
        begin
            unique case (i)
                3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
                3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
                3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
                3'd6: h = 32'h1f83d9ab; 3'd7: h = 32'h5be0cd19;
                default: h = 32'h0;
            endcase
            return h;
        end
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] sig_small0(input logic [31:0] x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] sig_small1(input logic [31:0] x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic logic [31:0] sig_big0(input logic [31:0] x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] sig_big1(input logic [31:0] x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

endpackage

// ----- design/sha256_byte_stream_hasher.sv -----
// SHA-256 hasher that takes a byte stream and returns the digest as eight words.
//
//   channel | direction | payload    | handshake
//   s_      | in        | sha_in_t   | s_valid / s_ready
//   m_      | out       | sha_out_t  | m_valid / m_ready
//
// A byte that does not complete a block is stored and the hasher stays ready. A
// byte that completes a block starts a load of the working words, 64 rounds of
// the one shared round datapath and a fold of the working words into the hash.
// A finish pads the buffer one byte per cycle, runs one or two compressions and
// then offers eight digest words, one per cycle while m_ready is high.
// Reset (aresetn low at a clock edge) restores the initial hash values and clears
// the fill count and length; the block buffer needs no clearing.
module sha256_byte_stream_hasher
    import sha256_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  sha_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output sha_out_t m_data
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_PAD   = 6'b000010,
        ST_LOAD  = 6'b000100,
        ST_ROUND = 6'b001000,
        ST_FOLD  = 6'b010000,
        ST_EMIT  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [31:0] buf_mem [16];
    logic [5:0]  fill_reg;
    logic [63:0] len_reg;
    logic [31:0] h_reg [8];
    logic [31:0] v_reg [8];
    logic [31:0] w_reg [16];
    logic [5:0]  round_reg;
    logic        finishing_reg;   // this compression belongs to a finish
    logic        len_written_reg; // the padded block with the length has been built
    logic        len_block_reg;   // the block being padded carries the length
    logic [2:0]  emit_idx_reg;

    logic        in_fire;
    logic        pad_wr;
    logic [7:0]  pad_byte;
    logic [4:0]  lane_lsb;
    logic [31:0] w_new, t1, t2;
    logic [31:0] w_buf;

    assign s_ready = (state_reg == ST_IDLE);
    assign in_fire = s_valid && s_ready;
    assign m_valid = (state_reg == ST_EMIT);
    assign m_data.digest_word = h_reg[emit_idx_reg];
    assign m_data.last_word   = (emit_idx_reg == 3'd7);

    // Bytes past the pad marker are zero, the last eight carry the bit length.
    always_comb begin
        if (fill_reg >= 6'd56 && len_block_reg && finishing_reg) begin
            pad_byte = len_reg[8'(63 - 8 * (32'(fill_reg) - 56)) -: 8];
        end else begin
            pad_byte = 8'h00;
        end
    end

    // The buffer holds big-endian words, so the first byte of a word goes to the top lane.
    assign lane_lsb = {~fill_reg[1:0], 3'b000};

    // Message word for rounds 0..15 comes from the buffer, later ones from the window.
    assign w_buf = buf_mem[round_reg[3:0]];

    always_comb begin
        if (round_reg < 6'd16) begin
            w_new = w_buf;
        end else begin
            w_new = sig_small1(w_reg[4'(round_reg - 6'd2)]) + w_reg[4'(round_reg - 6'd7)]
                  + sig_small0(w_reg[4'(round_reg - 6'd15)]) + w_reg[round_reg[3:0]];
        end
        t1 = v_reg[7] + sig_big1(v_reg[4]) + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
           + round_k(round_reg) + w_new;
        t2 = sig_big0(v_reg[0])
           + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
    end

    assign pad_wr = (state_reg == ST_PAD);

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            buf_mem[fill_reg[5:2]][lane_lsb +: 8] <=
                (s_data.op == OP_BYTE) ? s_data.data_byte : PAD_BYTE;
        end else if (pad_wr) begin
            buf_mem[fill_reg[5:2]][lane_lsb +: 8] <= pad_byte;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    if (s_data.op == OP_FINISH || fill_reg == 6'd63) begin
                        state_next = (s_data.op == OP_FINISH && fill_reg != 6'd63)
                                   ? ST_PAD : ST_LOAD;
                    end
                end
            end
            ST_PAD:   state_next = (fill_reg == 6'd63) ? ST_LOAD : ST_PAD;
            ST_LOAD:  state_next = ST_ROUND;
            ST_ROUND: state_next = (round_reg == 6'd63) ? ST_FOLD : ST_ROUND;
            ST_FOLD: begin
                if (!finishing_reg) begin
                    state_next = ST_IDLE;
                end else if (len_written_reg) begin
                    state_next = ST_EMIT;
                end else begin
                    state_next = ST_PAD;
                end
            end
            ST_EMIT: begin
                if (m_ready && emit_idx_reg == 3'd7) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            fill_reg        <= '0;
            len_reg         <= '0;
            round_reg       <= '0;
            finishing_reg   <= 1'b0;
            len_written_reg <= 1'b0;
            len_block_reg   <= 1'b0;
            emit_idx_reg    <= '0;
            for (int i = 0; i < 8; i++) begin
                h_reg[i] <= initial_h(3'(i));
            end
        end else begin
            state_reg <= state_next;
            unique case (state_reg)
                ST_IDLE: begin
                    if (in_fire) begin
                        fill_reg <= fill_reg + 6'd1;
                        if (s_data.op == OP_BYTE) begin
                            len_reg <= len_reg + 64'd8;
                        end else begin
                            finishing_reg   <= 1'b1;
                            len_written_reg <= 1'b0;
                            // The length fits behind the marker only if the marker lands
                            // before byte 56; otherwise a second block carries it.
                            len_block_reg   <= (fill_reg < 6'd56);
                        end
                    end
                end
                ST_PAD: begin
                    fill_reg <= fill_reg + 6'd1;
                    if (fill_reg == 6'd63 && len_block_reg && finishing_reg) begin
                        len_written_reg <= 1'b1;
                    end
                end
                ST_LOAD: begin
                    round_reg <= '0;
                    for (int i = 0; i < 8; i++) begin
                        v_reg[i] <= h_reg[i];
                    end
                end
                ST_ROUND: begin
                    w_reg[round_reg[3:0]] <= w_new;
                    for (int i = 1; i < 8; i++) begin
                        if (i != 4) begin
                            v_reg[i] <= v_reg[i - 1];
                        end
                    end
                    v_reg[4] <= v_reg[3] + t1;
                    v_reg[0] <= t1 + t2;
                    round_reg <= round_reg + 6'd1;
                end
                ST_FOLD: begin
                    for (int i = 0; i < 8; i++) begin
                        h_reg[i] <= h_reg[i] + v_reg[i];
                    end
                    if (finishing_reg && !len_written_reg) begin
                        len_block_reg <= 1'b1;
                    end
                end
                ST_EMIT: begin
                    if (m_ready) begin
                        emit_idx_reg <= emit_idx_reg + 3'd1;
                        if (emit_idx_reg == 3'd7) begin
                            for (int i = 0; i < 8; i++) begin
                                h_reg[i] <= initial_h(3'(i));
                            end
                            fill_reg      <= '0;
                            len_reg       <= '0;
                            finishing_reg <= 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    a_ready_only_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !m_valid)
        else $error("input ready while digest is offered");
    a_emit_steps: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_data.last_word) |=> m_valid)
        else $error("digest sequence broken");
    a_fold_after_round: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ROUND && round_reg == 6'd63) |=> state_reg == ST_FOLD)
        else $error("round count overrun");
    a_reset_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_data.last_word) |=> (fill_reg == 6'd0 && len_reg == 64'd0))
        else $error("message state not cleared after digest");

endmodule

// ----- verif/sha256_checker.sv -----
// Checker that predicts SHA-256 digest words from the input channel and compares them.
`timescale 1ns / 1ps
module sha256_checker
    import sha256_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    input  logic     s_ready,
    input  sha_in_t  s_data,
    input  logic     m_valid,
    input  logic     m_ready,
    input  sha_out_t m_data,
    output int       fail_count,
    output int       pending_words
);

    logic [7:0]  msg_block [64];
    logic [5:0]  fill_count;
    logic [63:0] bit_length;
    logic [31:0] hash_words [8];
    sha_out_t    digest_queue [$];

    function automatic logic [31:0] rot_right(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] k_const(input int t);
        logic [31:0] k_table [64];
        k_table = '{
            32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
            32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
            32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
            32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
            32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
            32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
            32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
            32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
            32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
            32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
            32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
        return k_table[t];
    endfunction

    task automatic init_hash();
        hash_words = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
                       32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
        fill_count = '0;
        bit_length = '0;
    endtask

    task automatic compress();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] t1, t2, s0, s1;
        for (int t = 0; t < 16; t++)
            w[t] = {msg_block[4*t], msg_block[4*t+1], msg_block[4*t+2], msg_block[4*t+3]};
        for (int t = 16; t < 64; t++) begin
            s0 = rot_right(w[t-15], 7) ^ rot_right(w[t-15], 18) ^ (w[t-15] >> 3);
            s1 = rot_right(w[t-2], 17) ^ rot_right(w[t-2], 19) ^ (w[t-2] >> 10);
            w[t] = s1 + w[t-7] + s0 + w[t-16];
        end
        v = hash_words;
        for (int t = 0; t < 64; t++) begin
            t1 = v[7] + (rot_right(v[4], 6) ^ rot_right(v[4], 11) ^ rot_right(v[4], 25))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + k_const(t) + w[t];
            t2 = (rot_right(v[0], 2) ^ rot_right(v[0], 13) ^ rot_right(v[0], 22))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            for (int i = 7; i > 0; i--) v[i] = v[i-1];
            v[4] = v[4] + t1;
            v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) hash_words[i] = hash_words[i] + v[i];
    endtask

    task automatic absorb_word(input sha_in_t item);
        int fill;
        sha_out_t word;
        fill = fill_count;
        if (item.op == OP_BYTE) begin
            msg_block[fill] = item.data_byte;
            bit_length = bit_length + 64'd8;
            fill++;
            if (fill == 64) begin
                compress();
                fill = 0;
            end
            fill_count = 6'(fill);
        end else begin
            msg_block[fill] = PAD_BYTE;
            fill++;
            if (fill > 56) begin
                while (fill < 64) msg_block[fill++] = 8'h00;
                compress();
                fill = 0;
            end
            while (fill < 56) msg_block[fill++] = 8'h00;
            for (int i = 0; i < 8; i++) msg_block[56+i] = bit_length[63-8*i -: 8];
            compress();
            for (int i = 0; i < 8; i++) begin
                word.digest_word = hash_words[i];
                word.last_word   = (i == 7);
                digest_queue.push_back(word);
            end
            init_hash();
        end
    endtask

    always @(posedge aclk) begin
        sha_out_t exp_word;
        int       errs;
        errs = 0;
        if (!aresetn) begin
            init_hash();
            digest_queue.delete();
            fail_count <= 0;
        end else begin
            if (s_valid && s_ready) absorb_word(s_data);
            if (m_valid && m_ready) begin
                if (digest_queue.size() == 0) begin
                    $error("unexpected digest word %h", m_data.digest_word);
                    errs++;
                end else begin
                    exp_word = digest_queue.pop_front();
                    if (m_data.digest_word !== exp_word.digest_word) begin
                        $error("digest_word expected %h actual %h",
                               exp_word.digest_word, m_data.digest_word);
                        errs++;
                    end
                    if (m_data.last_word !== exp_word.last_word) begin
                        $error("last_word expected %b actual %b",
                               exp_word.last_word, m_data.last_word);
                        errs++;
                    end
                end
            end
            fail_count <= fail_count + errs;
        end
        pending_words <= digest_queue.size();
    end

endmodule

// ----- verif/tb_top.sv -----
// Testbench top that drives byte streams and finish commands into the SHA-256 hasher.
`timescale 1ns / 1ps
module tb_top;
    import sha256_pkg::*;

    logic     aclk;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    sha_in_t  s_data;
    logic     m_valid;
    logic     m_ready = 1'b0;
    sha_out_t m_data;
    int       fail_count;
    int       pending_words;
    int       cycle_count = 0;
    logic     stall_mode = 1'b0;

    localparam int CYCLE_LIMIT = 400000;

    sha256_byte_stream_hasher u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    sha256_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .fail_count(fail_count), .pending_words(pending_words)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL sha256_byte_stream_hasher");
            $finish;
        end
    end

    // The receiver alternates between a steady phase and a stalling phase.
    always @(negedge aclk) begin
        if ($urandom_range(0, 63) == 0) stall_mode <= ~stall_mode;
        m_ready <= stall_mode ? ($urandom_range(0, 2) == 0) : 1'b1;
    end

    // Sends one word, sometimes with a random gap ahead of it.
    task automatic send_word(input logic op, input logic [7:0] data);
        if ($urandom_range(0, 7) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{op: op, data_byte: data};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic send_message(input int n_bytes);
        for (int i = 0; i < n_bytes; i++) send_word(OP_BYTE, 8'($urandom));
        send_word(OP_FINISH, 8'($urandom));
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Empty message, then extreme byte values, a finish carrying data and another empty message.
        send_word(OP_FINISH, 8'h00);
        send_word(OP_BYTE, 8'h00);
        send_word(OP_BYTE, 8'hff);
        send_word(OP_BYTE, 8'h55);
        send_word(OP_BYTE, 8'haa);
        send_word(OP_FINISH, 8'hff);
        send_word(OP_FINISH, 8'h5a);

        // One message whose pad marker lands past byte 55, or that fills a whole block.
        send_message($urandom_range(56, 64));

        for (int m = 0; m < 8; m++) begin
            send_message($urandom_range(0, 6));
        end
        s_valid <= 1'b0;

        while (pending_words != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (fail_count == 0)
            $display("PASS sha256_byte_stream_hasher");
        else
            $display("FAIL sha256_byte_stream_hasher");
        $finish;
    end

endmodule
